// ----- sv/assert_macros.svh -----
// Assertion helpers for the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication with synchronous reset disable
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication with synchronous reset disable
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- sv/pll_pkg.sv -----
// ----------------------------------------------------------------------------
// pll_pkg
// Types and constants for the piecewise linear lookup core.
// ----------------------------------------------------------------------------
package pll_pkg;
  localparam int unsigned RUN_WRAP = 10000;
  localparam int unsigned RUN_W    = 14;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned IDX_W    = 4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_DONE,
    ST_OUT
  } state_t;
endpackage

// ----- sv/pll_if.sv -----
// ----------------------------------------------------------------------------
// pll_in_if / pll_out_if
// Valid/ready channels for lookup requests and results.
// ----------------------------------------------------------------------------
interface pll_in_if #(parameter int VALUE_WIDTH = 32) (input logic clk);
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [pll_pkg::IDX_W-1:0]     point_index;
  logic signed [VALUE_WIDTH-1:0] point_u;
  logic signed [VALUE_WIDTH-1:0] point_v;
  logic signed [VALUE_WIDTH-1:0] sample_u;
  logic                          enable_in;
  modport source (output valid, opcode, point_index, point_u, point_v, sample_u,
                  enable_in, input ready);
  modport sink (input valid, opcode, point_index, point_u, point_v, sample_u,
                enable_in, output ready);
endinterface

interface pll_out_if #(parameter int VALUE_WIDTH = 32) (input logic clk);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value_out;
  logic                          enable_out;
  logic [pll_pkg::RUN_W-1:0]     run_count;
  modport source (output valid, value_out, enable_out, run_count, input ready);
  modport sink (input valid, value_out, enable_out, run_count, output ready);
endinterface

// ----- sv/pll_muldiv.sv -----
// ----------------------------------------------------------------------------
// pll_muldiv
// Unsigned a*b/d: shift-add multiply, then restoring divide, one bit a cycle.
// ----------------------------------------------------------------------------
module pll_muldiv #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] d,
  output logic         done,
  output logic [W-1:0] q
);
  localparam int PW = 2 * W;
  localparam int CW = $clog2(PW + 1);

  logic          busy_r, busy_nxt;
  logic          phase_r, phase_nxt;   // 0 multiply, 1 divide
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [W-1:0]  a_r, a_nxt;           // multiplicand, held for the whole multiply
  logic [W-1:0]  mb_r, mb_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  q_r, q_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    shifted;

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    a_nxt     = a_r;
    mb_nxt    = mb_r;
    d_nxt     = d_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    done_nxt  = 1'b0;
    shifted   = {rem_r[W-1:0], prod_r[PW-1]};
    if (start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      cnt_nxt   = CW'(W);
      prod_nxt  = '0;
      a_nxt     = a;
      mb_nxt    = b;
      d_nxt     = d;
      rem_nxt   = '0;
      q_nxt     = '0;
    end else if (busy_r && !phase_r) begin
      // shift-add over multiplier bits, LSB first
      if (mb_r[0]) begin
        prod_nxt = prod_r + (PW'(a_r) << (W - int'(cnt_r)));
      end
      mb_nxt  = mb_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        phase_nxt = 1'b1;
        cnt_nxt   = CW'(PW);
      end
    end else if (busy_r) begin
      prod_nxt = prod_r << 1;
      if (shifted >= {1'b0, d_r}) begin
        rem_nxt = shifted - {1'b0, d_r};
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    phase_r <= phase_nxt;
    cnt_r   <= cnt_nxt;
    prod_r  <= prod_nxt;
    a_r     <= a_nxt;
    mb_r    <= mb_nxt;
    d_r     <= d_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
  end

  assign done = done_r;
  assign q    = q_r;
endmodule

// ----- sv/piecewise_linear_lookup_core.sv -----
// ----------------------------------------------------------------------------
// piecewise_linear_lookup_core
// Maps a sample through up to MAX_POINTS checkpoints with linear interpolation.
// ----------------------------------------------------------------------------
// Load items write one (u,v) checkpoint and return nothing.
// An evaluate item returns one result. When enabled with two or more points in
// use it bubble-sorts a working copy, one compare-swap per cycle, scans the
// sorted points one per cycle, and for an interior sample runs a serial
// multiply and a serial divide. A disabled evaluate, or one with fewer than two
// points in use, goes through the done state to the output state; a clamped
// sample leaves the scan without stepping through the points, and an exact
// match skips the multiply and divide.
// The input is not ready while an item is in work or its result is waiting.
module piecewise_linear_lookup_core #(
  parameter int MAX_POINTS  = 10,
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  pll_in_if.sink     in_ch,
  pll_out_if.source  out_ch
);
  localparam int W  = VALUE_WIDTH;
  localparam int PI = $clog2(MAX_POINTS);

  typedef logic signed [W-1:0] val_t;

  pll_pkg::state_t state_r, state_nxt;

  val_t su_r [MAX_POINTS];
  val_t sv_r [MAX_POINTS];
  val_t wu_r [MAX_POINTS];
  val_t wv_r [MAX_POINTS];
  logic [pll_pkg::CNT_W-1:0] count_r;
  val_t                      held_r;
  logic [pll_pkg::RUN_W-1:0] run_r;
  logic                      en_r;
  val_t                      samp_r;
  logic [PI-1:0]             j_r;        // compare position / scan position
  logic [pll_pkg::CNT_W-1:0] pass_r;
  logic                      found_r;
  logic [PI-1:0]             hit_r;
  logic                      neg_r;
  logic                      md_start;
  logic                      md_done;
  logic [W-1:0]              md_q;
  logic [W-1:0]              md_a, md_b, md_d;
  logic [PI-1:0]             n_last;
  logic                      accept;

  assign n_last = PI'(count_r - 1'b1);
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == pll_pkg::ST_IDLE);
  assign out_ch.valid = (state_r == pll_pkg::ST_OUT);
  assign out_ch.value_out  = held_r;
  assign out_ch.enable_out = en_r;
  assign out_ch.run_count  = run_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pll_pkg::ST_IDLE: begin
        if (accept && in_ch.opcode == pll_pkg::OP_EVAL) begin
          if (in_ch.enable_in && count_r >= 4'd2) state_nxt = pll_pkg::ST_SORT;
          else                                    state_nxt = pll_pkg::ST_DONE;
        end
      end
      pll_pkg::ST_SORT: begin
        if (j_r == n_last && pass_r == count_r - 1'b1) state_nxt = pll_pkg::ST_SCAN;
      end
      pll_pkg::ST_SCAN: begin
        if (samp_r < wu_r[0] || samp_r > wu_r[n_last]) state_nxt = pll_pkg::ST_DONE;
        else if (j_r == n_last)                          state_nxt = pll_pkg::ST_MUL;
      end
      pll_pkg::ST_MUL:  state_nxt = found_r ? pll_pkg::ST_DONE : pll_pkg::ST_DIV;
      pll_pkg::ST_DIV:  if (md_done) state_nxt = pll_pkg::ST_DONE;
      pll_pkg::ST_DONE: state_nxt = pll_pkg::ST_OUT;
      pll_pkg::ST_OUT:  if (out_ch.ready) state_nxt = pll_pkg::ST_IDLE;
      default:          state_nxt = pll_pkg::ST_IDLE;
    endcase
  end

  // unit operands for the interior segment
  always_comb begin
    logic signed [W:0] dv;
    dv   = {wv_r[hit_r][W-1], wv_r[hit_r]} - {wv_r[hit_r-1'b1][W-1], wv_r[hit_r-1'b1]};
    md_a = dv[W] ? W'(-dv) : dv[W-1:0];
    md_b = W'(samp_r - wu_r[hit_r-1'b1]);
    md_d = W'(wu_r[hit_r] - wu_r[hit_r-1'b1]);
  end
  assign md_start = (state_r == pll_pkg::ST_MUL) && !found_r;

  pll_muldiv #(.W(W)) u_md (
    .clk(clk), .rst_n(rst_n), .start(md_start),
    .a(md_a), .b(md_b), .d(md_d), .done(md_done), .q(md_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pll_pkg::ST_IDLE;
      count_r <= '0;
      held_r  <= '0;
      run_r   <= '0;
      en_r    <= 1'b0;
      for (int i = 0; i < MAX_POINTS; i++) begin
        su_r[i] <= '0;
        sv_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        count_r <= (int'(cfg_wdata) > MAX_POINTS) ? 4'(MAX_POINTS) : cfg_wdata;
      end
      case (state_r)
        pll_pkg::ST_IDLE: begin
          if (accept && in_ch.opcode == pll_pkg::OP_LOAD) begin
            if (int'(in_ch.point_index) < MAX_POINTS) begin
              su_r[in_ch.point_index[PI-1:0]] <= in_ch.point_u;
              sv_r[in_ch.point_index[PI-1:0]] <= in_ch.point_v;
            end
          end else if (accept) begin
            en_r <= in_ch.enable_in && count_r >= 4'd2;
          end
        end
        pll_pkg::ST_SCAN: begin
          if (samp_r < wu_r[0])            held_r <= wv_r[0];
          else if (samp_r > wu_r[n_last])  held_r <= wv_r[n_last];
          else if (!found_r && samp_r == wu_r[j_r]) held_r <= wv_r[j_r];
        end
        pll_pkg::ST_DIV: begin
          if (md_done) held_r <= neg_r ? wv_r[hit_r-1'b1] - val_t'(md_q)
                                       : wv_r[hit_r-1'b1] + val_t'(md_q);
        end
        pll_pkg::ST_DONE: begin
          run_r <= (run_r == 14'(pll_pkg::RUN_WRAP - 1)) ? '0 : run_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // working copy, sort and scan datapath
  always_ff @(posedge clk) begin
    case (state_r)
      pll_pkg::ST_IDLE: begin
        samp_r <= in_ch.sample_u;
        j_r    <= PI'(1);
        pass_r <= 4'd1;
        for (int i = 0; i < MAX_POINTS; i++) begin
          wu_r[i] <= su_r[i];
          wv_r[i] <= sv_r[i];
        end
      end
      pll_pkg::ST_SORT: begin
        // one compare-swap of neighbors; advance position, then pass
        if (wu_r[j_r-1'b1] > wu_r[j_r]) begin
          wu_r[j_r-1'b1] <= wu_r[j_r];
          wv_r[j_r-1'b1] <= wv_r[j_r];
          wu_r[j_r]      <= wu_r[j_r-1'b1];
          wv_r[j_r]      <= wv_r[j_r-1'b1];
        end
        if (j_r == n_last) begin
          // restart at position one; after the last pass start the scan at zero
          j_r    <= (pass_r == count_r - 1'b1) ? '0 : PI'(1);
          pass_r <= pass_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
        found_r <= 1'b0;
        hit_r   <= PI'(1);
      end
      pll_pkg::ST_SCAN: begin
        if (samp_r == wu_r[j_r]) found_r <= 1'b1;
        if (j_r != '0 && samp_r > wu_r[j_r-1'b1] && samp_r < wu_r[j_r]) hit_r <= j_r;
        j_r <= j_r + 1'b1;
      end
      pll_pkg::ST_MUL: begin
        neg_r <= wv_r[hit_r] < wv_r[hit_r-1'b1];
      end
      default: ;
    endcase
  end
endmodule

// ----- sv/pll_checker.sv -----
// ----------------------------------------------------------------------------
// pll_checker
// Port-level checks for the piecewise linear lookup core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module pll_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_enable_out,
  input logic [13:0] out_run_count,
  input logic [31:0] out_value_out
);
  // never take a new item while a result waits
  `CHK_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready, "input ready during result")
  // run count stays below wrap
  `CHK_IMPL(a_run_range, clk, rst_n, out_valid, out_run_count < 14'd10000, "run count range")
  // hold a stalled result
  `CHK_NEXT(a_hold_stall, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value_out) && $stable(out_enable_out) && $stable(out_run_count), "stalled result changed")
  // a delivered result frees the input
  `CHK_NEXT(a_free, clk, rst_n, out_valid && out_ready, in_ready, "input not freed")
endmodule

bind piecewise_linear_lookup_core pll_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_enable_out(out_ch.enable_out), .out_run_count(out_ch.run_count),
  .out_value_out(32'(out_ch.value_out))
);
